// ----- hw/rtl/ath_pkg.sv -----
// ----------------------------------------------------------------------------
// ath_pkg
// Shared types and constants of the tilt detector.
// ----------------------------------------------------------------------------
`default_nettype none
package ath_pkg;
  localparam int SUM_W = 24;
  localparam int AX_W  = 16;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_LOCKED = 2'd2;
  localparam logic [1:0] ST_FAILED = 2'd3;

  localparam logic [1:0] REG_BASE_LEN  = 2'd0;
  localparam logic [1:0] REG_MEAS_LEN  = 2'd1;
  localparam logic [1:0] REG_COS_OPEN  = 2'd2;
  localparam logic [1:0] REG_COS_CLOSE = 2'd3;

  typedef struct packed {
    logic                    read_ok;
    logic signed [AX_W-1:0]  accel_x;
    logic signed [AX_W-1:0]  accel_y;
    logic signed [AX_W-1:0]  accel_z;
  } sample_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    tilt_open;
    logic                    crossed_open;
    logic                    crossed_close;
    logic [7:0]              valid_count;
    logic signed [SUM_W-1:0] window_sum_x;
    logic signed [SUM_W-1:0] window_sum_y;
    logic signed [SUM_W-1:0] window_sum_z;
  } result_t;

  // product terms per lane, accumulated by the merge stage
  typedef struct packed {
    logic signed [47:0] aa;
    logic signed [47:0] bb;
    logic signed [47:0] dot;
  } lane_prod_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ath_stream_if.sv -----
// ----------------------------------------------------------------------------
// ath_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface ath_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/accel_tilt_hysteresis_detector.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_hysteresis_detector
// Window averaging tilt detector with open/close hysteresis.
// ----------------------------------------------------------------------------
// channel   dir  payload
// smp       in   read_ok, accel_x/y/z
// res       out  status, tilt flags, valid_count, window sums
//
// Samples that do not end a window are taken back to back. A window end
// that needs the angle test raises the result once the compare unit has
// run, once per threshold. Reset clears counters, phase and tilt state.
// A held result or a running angle test stalls input. After a failed
// baseline, sample beats are taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none
module accel_tilt_hysteresis_detector #(
  parameter int COUNT_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  ath_stream_if.sink      smp,
  ath_stream_if.source    res
);
  import ath_pkg::*;

  localparam logic [1:0] PH_BASE = 2'd0;
  localparam logic [1:0] PH_MEAS = 2'd1;
  localparam logic [1:0] PH_HALT = 2'd2;
  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_PROD  = 3'd1;
  localparam logic [2:0] C_SUM   = 3'd2;
  localparam logic [2:0] C_OPEN  = 3'd3;
  localparam logic [2:0] C_CLOSE = 3'd4;
  localparam logic [2:0] C_START = 3'd5;

  logic [7:0]  base_len, meas_len;
  logic signed [15:0] cos_open, cos_close;
  logic [1:0]  phase;
  logic [COUNT_BITS-1:0] slot;
  logic [7:0]  vcnt;
  logic        tilt;
  logic [2:0]  cst;
  logic        open_hit;
  logic        out_valid;
  result_t     out_data;

  sample_t     s;
  logic        acc_fire, add, win_end, lock, calc;
  logic [7:0]  len;
  logic signed [SUM_W-1:0] sx, sy, sz;
  lane_prod_t  px, py, pz;
  logic signed [49:0] dot;
  logic [49:0] aa, bb;
  logic        cmp_start, cmp_done;
  logic signed [1:0] cmp_sgn;

  assign s        = smp.data;
  assign smp.ready = (cst == C_IDLE) && !out_valid;
  assign acc_fire = smp.valid && smp.ready && (phase != PH_HALT);
  assign add      = acc_fire && s.read_ok && (slot != '0);
  assign len      = (phase == PH_BASE) ? base_len : meas_len;
  assign win_end  = ({{(32-COUNT_BITS){1'b0}}, slot} + 32'd1 >= 32'(len)) ||
                    (slot == {COUNT_BITS{1'b1}});
  assign lock     = acc_fire && win_end && (phase == PH_BASE);
  assign calc     = (cst == C_PROD);

  ath_lane u_lx (.clk, .add, .clear(rst || res.valid && res.ready), .lock, .calc,
                 .sample(s.accel_x), .sum(sx), .prod(px));
  ath_lane u_ly (.clk, .add, .clear(rst || res.valid && res.ready), .lock, .calc,
                 .sample(s.accel_y), .sum(sy), .prod(py));
  ath_lane u_lz (.clk, .add, .clear(rst || res.valid && res.ready), .lock, .calc,
                 .sample(s.accel_z), .sum(sz), .prod(pz));

  assign cmp_start = (cst == C_START) || (cst == C_OPEN && cmp_done);

  ath_cmp u_cmp (.clk, .rst, .start(cmp_start), .dot, .aa, .bb,
                 .cval((cst == C_START) ? cos_open : cos_close),
                 .done(cmp_done), .sgn(cmp_sgn));

  always_ff @(posedge clk) begin
    if (rst) begin
      base_len  <= 8'd50;
      meas_len  <= 8'd10;
      cos_open  <= 16'sd16384;
      cos_close <= 16'sd25101;
      phase     <= PH_BASE;
      slot      <= '0;
      vcnt      <= '0;
      tilt      <= 1'b0;
      cst       <= C_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE_LEN:  base_len  <= cfg_data[7:0];
          REG_MEAS_LEN:  meas_len  <= cfg_data[7:0];
          REG_COS_OPEN:  cos_open  <= cfg_data;
          default:       cos_close <= cfg_data;
        endcase
      end
      if (res.valid && res.ready) begin
        out_valid <= 1'b0;
        vcnt      <= '0;
      end
      if (acc_fire) begin
        if (add) vcnt <= vcnt + 8'd1;
        if (!win_end) begin
          slot <= slot + COUNT_BITS'(1);
        end else begin
          slot <= '0;
          if (vcnt == '0 && !add) begin
            out_data <= '{status: (phase == PH_BASE) ? ST_FAILED : ST_EMPTY,
                          tilt_open: (phase == PH_BASE) ? 1'b0 : tilt,
                          default: '0};
            if (phase == PH_BASE) phase <= PH_HALT;
            out_valid <= 1'b1;
          end else if (phase == PH_BASE) begin
            phase <= PH_MEAS;
            out_valid <= 1'b1;
            out_data <= '{status: ST_LOCKED,
                          valid_count: vcnt + 8'(add),
                          window_sum_x: sx + (add ? SUM_W'(s.accel_x) : '0),
                          window_sum_y: sy + (add ? SUM_W'(s.accel_y) : '0),
                          window_sum_z: sz + (add ? SUM_W'(s.accel_z) : '0),
                          default: '0};
          end else begin
            cst <= C_PROD;
            out_data <= '{valid_count: vcnt + 8'(add), default: '0};
          end
        end
      end
      unique case (cst)
        C_PROD: begin
          out_data.window_sum_x <= sx;
          out_data.window_sum_y <= sy;
          out_data.window_sum_z <= sz;
          cst <= C_SUM;
        end
        C_SUM: begin
          dot <= 50'(px.dot) + 50'(py.dot) + 50'(pz.dot);
          aa  <= 50'(px.aa) + 50'(py.aa) + 50'(pz.aa);
          bb  <= 50'(px.bb) + 50'(py.bb) + 50'(pz.bb);
          cst <= C_START;
        end
        C_START: begin
          cst <= C_OPEN;
        end
        C_OPEN: begin
          if (cmp_done) begin
            open_hit <= (cmp_sgn < 0);
            cst <= C_CLOSE;
          end
        end
        C_CLOSE: begin
          if (cmp_done) begin
            cst <= C_IDLE;
            out_valid <= 1'b1;
            out_data.status <= ST_DONE;
            if (aa == '0 || bb == '0) begin
              if (tilt) begin
                tilt <= 1'b0;
                out_data.crossed_close <= 1'b1;
              end
              out_data.tilt_open <= 1'b0;
            end else if (!tilt && open_hit) begin
              tilt <= 1'b1;
              out_data.crossed_open <= 1'b1;
              out_data.tilt_open <= 1'b1;
            end else if (tilt && cmp_sgn > 0) begin
              tilt <= 1'b0;
              out_data.crossed_close <= 1'b1;
              out_data.tilt_open <= 1'b0;
            end else begin
              out_data.tilt_open <= tilt;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;
endmodule
`default_nettype wire

// ----- hw/rtl/ath_lane.sv -----
// ----------------------------------------------------------------------------
// ath_lane
// One axis: accumulates samples and forms its product terms at window end.
// ----------------------------------------------------------------------------
`default_nettype none
module ath_lane (
  input  wire logic                          clk,
  input  wire logic                          add,
  input  wire logic                          clear,
  input  wire logic                          lock,
  input  wire logic                          calc,
  input  wire logic signed [ath_pkg::AX_W-1:0]  sample,
  output logic signed [ath_pkg::SUM_W-1:0]      sum,
  output ath_pkg::lane_prod_t                   prod
);
  import ath_pkg::*;

  logic signed [SUM_W-1:0] base;

  always_ff @(posedge clk) begin
    if (clear) begin
      sum <= '0;
    end else if (add) begin
      sum <= sum + SUM_W'(sample);
    end
    // take the last slot's sample into the baseline as well
    if (lock) begin
      base <= add ? sum + SUM_W'(sample) : sum;
    end
    if (calc) begin
      prod.aa  <= sum * sum;
      prod.bb  <= base * base;
      prod.dot <= sum * base;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ath_cmp.sv -----
// ----------------------------------------------------------------------------
// ath_cmp
// Sequential cosine comparison: sign of dot*32768 - c*sqrt(aa*bb).
// Multiplies sequentially in 32-bit slices.
// ----------------------------------------------------------------------------
`default_nettype none
module ath_cmp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [49:0] dot,
  input  wire logic [49:0]        aa,
  input  wire logic [49:0]        bb,
  input  wire logic signed [15:0] cval,
  output logic                    done,
  output logic signed [1:0]       sgn
);
  import ath_pkg::*;

  // L = |dot|*32768 (<=65 bits), square ~130 bits; R = aa*bb*c^2
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LL   = 3'd1;
  localparam logic [2:0] S_AB   = 3'd2;
  localparam logic [2:0] S_RC   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;

  logic [2:0]   state;
  logic [2:0]   step;
  logic [63:0]  la;       // |dot|, shift applied later
  logic [31:0]  uc2;
  logic [135:0] acc;
  logic [135:0] lsq;
  logic [135:0] ab;
  logic         sl_pos, sl_zero, sr_pos, sr_zero;
  logic [63:0]  opa;
  logic [63:0]  opb;
  logic [31:0]  ma, mb;
  logic [63:0]  pp;
  logic [1:0]   ia, ib;

  // operand slices: step selects a 32x32 partial product of a 64x64 one
  assign ia = {1'b0, step[0]};
  assign ib = {1'b0, step[1]};
  assign ma = ia[0] ? opa[63:32] : opa[31:0];
  assign mb = ib[0] ? opb[63:32] : opb[31:0];
  assign pp = ma * mb;

  always_comb begin
    opa = la;
    opb = la;
    unique case (state)
      S_AB: begin
        opa = 64'(aa);
        opb = 64'(bb);
      end
      default: begin
        opa = la;
        opb = la;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            la      <= dot[49] ? 64'(-dot) : 64'(dot);
            sl_pos  <= !dot[49] && (dot != '0);
            sl_zero <= (dot == '0);
            sr_pos  <= !cval[15] && (cval != '0);
            sr_zero <= (cval == '0);
            uc2     <= 32'(cval[15] ? -32'(cval) : 32'(cval)) *
                       32'(cval[15] ? -32'(cval) : 32'(cval));
            acc     <= '0;
            step    <= '0;
            state   <= S_LL;
          end
        end
        S_LL: begin
          acc  <= acc + (136'(pp) << (32 * (32'(ia[0]) + 32'(ib[0]))));
          step <= step + 3'd1;
          if (step == 3'd3) begin
            state <= S_AB;
            step  <= '0;
          end
        end
        S_AB: begin
          if (step == 3'd0) begin
            lsq <= acc << 30;
            acc <= 136'(pp);
          end else begin
            acc <= acc + (136'(pp) << (32 * (32'(ia[0]) + 32'(ib[0]))));
          end
          step <= step + 3'd1;
          if (step == 3'd3) begin
            state <= S_RC;
            step  <= '0;
          end
        end
        S_RC: begin
          // ab <= 100 bits, times an up to 31-bit c^2: four 32-bit slices
          if (step == 3'd0) begin
            ab  <= acc;
            acc <= '0;
          end else begin
            acc <= acc + (136'(ab[32*(step-3'd1) +: 32] * uc2) << (32 * (step - 3'd1)));
          end
          step <= step + 3'd1;
          if (step == 3'd4) begin
            state <= S_CMP;
          end
        end
        default: begin
          if (sl_zero && sr_zero) sgn <= 2'sd0;
          else if ((sl_pos ? 2 : (sl_zero ? 1 : 0)) != (sr_pos ? 2 : (sr_zero ? 1 : 0)))
            sgn <= ((sl_pos ? 2 : (sl_zero ? 1 : 0)) < (sr_pos ? 2 : (sr_zero ? 1 : 0)))
                   ? -2'sd1 : 2'sd1;
          else if (lsq == acc) sgn <= 2'sd0;
          else if ((lsq < acc) == sl_pos) sgn <= -2'sd1;
          else sgn <= 2'sd1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire
